// ===== src/vrp_pkg.sv =====
// ----------------------------------------------------------------------------
// vrp_pkg: shared types, codes and helpers of the video register port
// Command and register codes, memory map constants, the stage-two payload
// and memory request structs, and the nametable/palette index helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vrp_pkg;

   // Commands carried in req_tuser
   localparam logic [2:0] CMD_READ      = 3'd0;
   localparam logic [2:0] CMD_WRITE     = 3'd1;
   localparam logic [2:0] CMD_VBLANK    = 3'd2;
   localparam logic [2:0] CMD_PRERENDER = 3'd3;
   localparam logic [2:0] CMD_HIT       = 3'd4;
   localparam logic [2:0] CMD_OVERFLOW  = 3'd5;

   // Register numbers
   localparam logic [2:0] REG_CONTROL   = 3'd0;
   localparam logic [2:0] REG_MASK      = 3'd1;
   localparam logic [2:0] REG_STATUS    = 3'd2;
   localparam logic [2:0] REG_OAM_ADDR  = 3'd3;
   localparam logic [2:0] REG_OAM_DATA  = 3'd4;
   localparam logic [2:0] REG_SCROLL    = 3'd5;
   localparam logic [2:0] REG_ADDR      = 3'd6;
   localparam logic [2:0] REG_DATA      = 3'd7;

   // Nametable mirroring modes
   localparam logic [1:0] MIR_HORIZONTAL = 2'd0;
   localparam logic [1:0] MIR_VERTICAL   = 2'd1;
   localparam logic [1:0] MIR_SINGLE_LO  = 2'd2;
   localparam logic [1:0] MIR_SINGLE_HI  = 2'd3;

   // Open-bus update done in stage two
   localparam logic [2:0] OB_KEEP   = 3'd0;
   localparam logic [2:0] OB_LOAD   = 3'd1;
   localparam logic [2:0] OB_STATUS = 3'd2;
   localparam logic [2:0] OB_MEM    = 3'd3;
   localparam logic [2:0] OB_BUFFER = 3'd4;

   // Memory selects
   localparam logic [1:0] SRC_SPRITE    = 2'd0;
   localparam logic [1:0] SRC_PATTERN   = 2'd1;
   localparam logic [1:0] SRC_NAMETABLE = 2'd2;
   localparam logic [1:0] SRC_PALETTE   = 2'd3;

   // Sizes and memory map
   localparam int NAMETABLE_BYTES_DEF = 2048;
   localparam int PATTERN_BYTES       = 8192;
   localparam int PALETTE_ENTRIES     = 32;
   localparam int SPRITE_BYTES        = 256;
   localparam int PALETTE_WIDTH       = 6;

   localparam logic [13:0] PATTERN_LIMIT = 14'h2000;
   localparam logic [13:0] PALETTE_BASE  = 14'h3f00;

   // Status flag bits
   localparam int ST_VBLANK   = 2;
   localparam int ST_HIT      = 1;
   localparam int ST_OVERFLOW = 0;

   // Memory access issued on the accept edge
   typedef struct packed {
      logic        rd;
      logic        wr;
      logic [1:0]  src;
      logic [12:0] addr;
      logic [7:0]  wdata;
   } mem_req_type;

   // Payload of stage two
   typedef struct packed {
      logic [2:0]  ob_op;
      logic [1:0]  src;
      logic [7:0]  wr_byte;
      logic [2:0]  status;
      logic        nmi;
      logic [14:0] vram;
      logic [2:0]  fine;
      logic [7:0]  control;
      logic [7:0]  mask;
   } stage_type;

   // Result beat
   typedef struct packed {
      logic [7:0]  read_data;
      logic        nmi;
      logic [14:0] vram;
      logic [2:0]  fine;
      logic [7:0]  control;
      logic [7:0]  mask;
   } rsp_type;

   // Nametable index under the four mirroring modes
   function automatic logic [10:0] nt_index(input logic [1:0] mirroring,
                                            input logic [13:0] a);
      logic [10:0] idx;
      case (mirroring)
         MIR_HORIZONTAL: idx = {a[11], a[9:0]};
         MIR_VERTICAL:   idx = a[10:0];
         MIR_SINGLE_LO:  idx = {1'b0, a[9:0]};
         default:        idx = {1'b1, a[9:0]};
      endcase
      return idx;
   endfunction

   // Palette index; backdrop entries of sprite palettes fold down
   function automatic logic [4:0] pal_index(input logic [13:0] a);
      logic [4:0] p;
      p = a[4:0];
      if (p[4] && (p[1:0] == 2'b00)) begin
         p[4] = 1'b0;
      end
      return p;
   endfunction

endpackage

// ===== src/video_register_port.sv =====
// ----------------------------------------------------------------------------
// video_register_port: CPU-facing register file of a tile video processor
// Eight mirrored registers, nametable/palette/sprite/pattern memories,
// status flags driven by frame events and nmi on vblank begin.
// ----------------------------------------------------------------------------
//   channel | dir | handshake            | payload
//   req     | in  | req_tvalid/tready    | tuser cmd, reg_index; tdata write_data
//   rsp     | out | rsp_tvalid/tready    | tdata read_data .. mask_value
//   csr     | in  | csr_valid/ready      | csr_data mirroring
//
// One beat is accepted per cycle while req_tready is high. The accept edge
// updates the register state, issues the memory access and loads stage
// two; when stage two advances, the RAM read data is folded into the
// open-bus latch and the result register is loaded.
// Reset is synchronous; memories are not cleared.
// With rsp_tready low, a held result stalls a full stage two; req_tready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module video_register_port #(
   parameter int NAMETABLE_BYTES = vrp_pkg::NAMETABLE_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [5:0]  req_tuser,   // cmd[2:0], reg_index[5:3]
   input  logic [7:0]  req_tdata,   // write_data[7:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_data[7:0], nmi_pulse[8], current_vram_address[23:9],
   // fine_scroll_x[26:24], control_value[34:27], mask_value[42:35], zero[47:43]
   output logic [47:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_data     // mirroring[1:0]
);

   localparam int NT_AW = $clog2(NAMETABLE_BYTES);
   localparam int PT_AW = $clog2(vrp_pkg::PATTERN_BYTES);
   localparam int PL_AW = $clog2(vrp_pkg::PALETTE_ENTRIES);
   localparam int SP_AW = $clog2(vrp_pkg::SPRITE_BYTES);

   logic                 mid_ready;
   logic                 mid_load;
   vrp_pkg::stage_type   mid_data;
   vrp_pkg::mem_req_type mem_req;
   vrp_pkg::rsp_type     rsp;

   logic [7:0] sprite_rd;
   logic [7:0] pattern_rd;
   logic [7:0] nametable_rd;
   logic [5:0] palette_rd;

   logic sprite_sel, pattern_sel, nametable_sel, palette_sel;
   logic [NT_AW-1:0] nt_addr;

   assign req_tready = mid_ready;

   // register state and memory request
   vrp_exec u_exec (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .mid_ready  (mid_ready),
      .mid_load   (mid_load),
      .mid_data   (mid_data),
      .mem_req    (mem_req)
   );

   // memory select
   assign sprite_sel    = (mem_req.src == vrp_pkg::SRC_SPRITE);
   assign pattern_sel   = (mem_req.src == vrp_pkg::SRC_PATTERN);
   assign nametable_sel = (mem_req.src == vrp_pkg::SRC_NAMETABLE);
   assign palette_sel   = (mem_req.src == vrp_pkg::SRC_PALETTE);
   assign nt_addr       = NT_AW'(mem_req.addr[10:0]);

   vrp_ram #(.WIDTH(8), .DEPTH(vrp_pkg::SPRITE_BYTES)) u_sprite_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr && sprite_sel),
      .wr_addr (mem_req.addr[SP_AW-1:0]),
      .wr_data (mem_req.wdata),
      .rd_en   (mem_req.rd && sprite_sel),
      .rd_addr (mem_req.addr[SP_AW-1:0]),
      .rd_data (sprite_rd)
   );

   vrp_ram #(.WIDTH(8), .DEPTH(vrp_pkg::PATTERN_BYTES)) u_pattern_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr && pattern_sel),
      .wr_addr (mem_req.addr[PT_AW-1:0]),
      .wr_data (mem_req.wdata),
      .rd_en   (mem_req.rd && pattern_sel),
      .rd_addr (mem_req.addr[PT_AW-1:0]),
      .rd_data (pattern_rd)
   );

   vrp_ram #(.WIDTH(8), .DEPTH(NAMETABLE_BYTES)) u_nametable_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr && nametable_sel),
      .wr_addr (nt_addr),
      .wr_data (mem_req.wdata),
      .rd_en   (mem_req.rd && nametable_sel),
      .rd_addr (nt_addr),
      .rd_data (nametable_rd)
   );

   vrp_ram #(.WIDTH(vrp_pkg::PALETTE_WIDTH), .DEPTH(vrp_pkg::PALETTE_ENTRIES)) u_palette_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr && palette_sel),
      .wr_addr (mem_req.addr[PL_AW-1:0]),
      .wr_data (mem_req.wdata[vrp_pkg::PALETTE_WIDTH-1:0]),
      .rd_en   (mem_req.rd && palette_sel),
      .rd_addr (mem_req.addr[PL_AW-1:0]),
      .rd_data (palette_rd)
   );

   // open-bus, read buffer and result register
   vrp_resolve u_resolve (
      .clock        (clock),
      .reset        (reset),
      .mid_load     (mid_load),
      .mid_data     (mid_data),
      .mid_ready    (mid_ready),
      .sprite_rd    (sprite_rd),
      .pattern_rd   (pattern_rd),
      .nametable_rd (nametable_rd),
      .palette_rd   (palette_rd),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp          (rsp)
   );

   // result beat packing
   assign rsp_tdata = {5'd0, rsp.mask, rsp.control, rsp.fine, rsp.vram,
                       rsp.nmi, rsp.read_data};

endmodule

// ===== src/vrp_ram.sv =====
// ----------------------------------------------------------------------------
// vrp_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vrp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/vrp_exec.sv =====
// ----------------------------------------------------------------------------
// vrp_exec: register state and memory access of the video register port
// Applies each accepted beat to the register state, issues its memory
// access and hands the post-step state to stage two.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vrp_exec (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [1:0]           csr_data,
   input  logic                 req_tvalid,
   input  logic [5:0]           req_tuser,   // cmd[2:0], reg_index[5:3]
   input  logic [7:0]           req_tdata,   // write_data[7:0]
   input  logic                 mid_ready,
   output logic                 mid_load,
   output vrp_pkg::stage_type   mid_data,
   output vrp_pkg::mem_req_type mem_req
);

   logic [1:0]  mirroring_ff;
   logic [7:0]  control_ff, control_in;
   logic [7:0]  mask_ff, mask_in;
   logic [2:0]  status_ff, status_in;
   logic [7:0]  sprite_addr_ff, sprite_addr_in;
   logic        toggle_ff, toggle_in;
   logic [14:0] vram_ff, vram_in;
   logic [14:0] temp_ff, temp_in;
   logic [2:0]  fine_ff, fine_in;

   logic        fire;
   logic [2:0]  cmd;
   logic [2:0]  reg_sel;
   logic [7:0]  wbyte;
   logic [13:0] mem_addr;
   logic [14:0] vram_step;
   logic [1:0]  data_src;
   logic [12:0] data_addr;

   assign cmd       = req_tuser[2:0];
   assign reg_sel   = req_tuser[5:3];
   assign wbyte     = req_tdata;
   assign fire      = req_tvalid && mid_ready;
   assign mid_load  = fire;
   assign csr_ready = 1'b1;
   assign mem_addr  = vram_ff[13:0];

   // address advance wraps in 14 bits, bit 14 kept
   assign vram_step = {vram_ff[14],
                       mem_addr + (control_ff[2] ? 14'd32 : 14'd1)};

   // data-port decode of the memory map
   always_comb begin
      if (mem_addr < vrp_pkg::PATTERN_LIMIT) begin
         data_src  = vrp_pkg::SRC_PATTERN;
         data_addr = mem_addr[12:0];
      end else if (mem_addr < vrp_pkg::PALETTE_BASE) begin
         data_src  = vrp_pkg::SRC_NAMETABLE;
         data_addr = {2'b00, vrp_pkg::nt_index(mirroring_ff, mem_addr)};
      end else begin
         data_src  = vrp_pkg::SRC_PALETTE;
         data_addr = {8'd0, vrp_pkg::pal_index(mem_addr)};
      end
   end

   // next state, memory request and stage-two payload
   always_comb begin
      control_in     = control_ff;
      mask_in        = mask_ff;
      status_in      = status_ff;
      sprite_addr_in = sprite_addr_ff;
      toggle_in      = toggle_ff;
      vram_in        = vram_ff;
      temp_in        = temp_ff;
      fine_in        = fine_ff;

      mem_req.rd    = 1'b0;
      mem_req.wr    = 1'b0;
      mem_req.src   = data_src;
      mem_req.addr  = data_addr;
      mem_req.wdata = wbyte;

      mid_data.ob_op   = vrp_pkg::OB_KEEP;
      mid_data.src     = data_src;
      mid_data.wr_byte = wbyte;
      mid_data.status  = status_ff;
      mid_data.nmi     = 1'b0;

      case (cmd)
         vrp_pkg::CMD_READ: begin
            case (reg_sel)
               vrp_pkg::REG_STATUS: begin
                  mid_data.ob_op = vrp_pkg::OB_STATUS;
                  toggle_in = 1'b0;
                  status_in[vrp_pkg::ST_VBLANK] = 1'b0;
               end
               vrp_pkg::REG_OAM_DATA: begin
                  mid_data.ob_op = vrp_pkg::OB_MEM;
                  mid_data.src   = vrp_pkg::SRC_SPRITE;
                  mem_req.rd     = 1'b1;
                  mem_req.src    = vrp_pkg::SRC_SPRITE;
                  mem_req.addr   = {5'd0, sprite_addr_ff};
               end
               vrp_pkg::REG_DATA: begin
                  mem_req.rd = 1'b1;
                  if (data_src == vrp_pkg::SRC_PALETTE) begin
                     mid_data.ob_op = vrp_pkg::OB_MEM;
                  end else begin
                     mid_data.ob_op = vrp_pkg::OB_BUFFER;
                  end
                  vram_in = vram_step;
               end
               default: begin
               end
            endcase
         end
         vrp_pkg::CMD_WRITE: begin
            mid_data.ob_op = vrp_pkg::OB_LOAD;
            case (reg_sel)
               vrp_pkg::REG_CONTROL: begin
                  control_in     = wbyte;
                  temp_in[11:10] = wbyte[1:0];
               end
               vrp_pkg::REG_MASK: begin
                  mask_in = wbyte;
               end
               vrp_pkg::REG_OAM_ADDR: begin
                  sprite_addr_in = wbyte;
               end
               vrp_pkg::REG_OAM_DATA: begin
                  mem_req.wr     = 1'b1;
                  mem_req.src    = vrp_pkg::SRC_SPRITE;
                  mem_req.addr   = {5'd0, sprite_addr_ff};
                  sprite_addr_in = sprite_addr_ff + 8'd1;
               end
               vrp_pkg::REG_SCROLL: begin
                  if (!toggle_ff) begin
                     temp_in[4:0] = wbyte[7:3];
                     fine_in      = wbyte[2:0];
                  end else begin
                     temp_in[9:5]   = wbyte[7:3];
                     temp_in[14:12] = wbyte[2:0];
                  end
                  toggle_in = !toggle_ff;
               end
               vrp_pkg::REG_ADDR: begin
                  if (!toggle_ff) begin
                     temp_in = {1'b0, wbyte[5:0], temp_ff[7:0]};
                  end else begin
                     temp_in = {temp_ff[14:8], wbyte};
                     vram_in = {temp_ff[14:8], wbyte};
                  end
                  toggle_in = !toggle_ff;
               end
               vrp_pkg::REG_DATA: begin
                  mem_req.wr = 1'b1;
                  vram_in    = vram_step;
               end
               default: begin
               end
            endcase
         end
         vrp_pkg::CMD_VBLANK: begin
            status_in[vrp_pkg::ST_VBLANK] = 1'b1;
            mid_data.nmi = control_ff[7];
         end
         vrp_pkg::CMD_PRERENDER: begin
            status_in = 3'b000;
         end
         vrp_pkg::CMD_HIT: begin
            status_in[vrp_pkg::ST_HIT] = 1'b1;
         end
         vrp_pkg::CMD_OVERFLOW: begin
            status_in[vrp_pkg::ST_OVERFLOW] = 1'b1;
         end
         default: begin
         end
      endcase

      // memory access only on an accepted beat
      mem_req.rd = mem_req.rd && fire;
      mem_req.wr = mem_req.wr && fire;

      mid_data.vram    = vram_in;
      mid_data.fine    = fine_in;
      mid_data.control = control_in;
      mid_data.mask    = mask_in;
   end

   // register state
   always_ff @(posedge clock) begin
      if (reset) begin
         mirroring_ff   <= vrp_pkg::MIR_VERTICAL;
         control_ff     <= 8'd0;
         mask_ff        <= 8'd0;
         status_ff      <= 3'b101;
         sprite_addr_ff <= 8'd0;
         toggle_ff      <= 1'b0;
         vram_ff        <= 15'd0;
         temp_ff        <= 15'd0;
         fine_ff        <= 3'd0;
      end else begin
         if (csr_valid && csr_ready) begin
            mirroring_ff <= csr_data;
         end
         if (fire) begin
            control_ff     <= control_in;
            mask_ff        <= mask_in;
            status_ff      <= status_in;
            sprite_addr_ff <= sprite_addr_in;
            toggle_ff      <= toggle_in;
            vram_ff        <= vram_in;
            temp_ff        <= temp_in;
            fine_ff        <= fine_in;
         end
      end
   end

`ifndef SYNTHESIS
   // a status read resets the write toggle
   a_status_clears_toggle: assert property (@(posedge clock) disable iff (reset)
      fire && (cmd == vrp_pkg::CMD_READ) && (reg_sel == vrp_pkg::REG_STATUS)
      |=> !toggle_ff)
      else $error("write toggle not cleared by status read");

   // data-port advance keeps address bit 14
   a_step_keeps_bit14: assert property (@(posedge clock) disable iff (reset)
      fire && (reg_sel == vrp_pkg::REG_DATA)
      && ((cmd == vrp_pkg::CMD_READ) || (cmd == vrp_pkg::CMD_WRITE))
      |=> vram_ff[14] == $past(vram_ff[14]))
      else $error("data-port advance changed address bit 14");

   // nmi comes only from vblank begin
   a_nmi_source: assert property (@(posedge clock) disable iff (reset)
      fire && mid_data.nmi |-> (cmd == vrp_pkg::CMD_VBLANK) && control_ff[7])
      else $error("nmi raised outside vblank begin");
`endif

endmodule

// ===== src/vrp_resolve.sv =====
// ----------------------------------------------------------------------------
// vrp_resolve: open-bus, read buffer and result register
// Stage two merges the memory read data into the open-bus latch and the
// read buffer, then loads the result register that drives the rsp side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vrp_resolve (
   input  logic               clock,
   input  logic               reset,
   input  logic               mid_load,
   input  vrp_pkg::stage_type mid_data,
   output logic               mid_ready,
   input  logic [7:0]         sprite_rd,
   input  logic [7:0]         pattern_rd,
   input  logic [7:0]         nametable_rd,
   input  logic [5:0]         palette_rd,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output vrp_pkg::rsp_type   rsp
);

   logic               mid_valid_ff, mid_valid_in;
   vrp_pkg::stage_type mid_ff;
   logic               out_valid_ff, out_valid_in;
   vrp_pkg::rsp_type   out_ff;
   logic [7:0]         open_bus_ff, open_bus_in;
   logic [7:0]         read_buffer_ff, read_buffer_in;
   logic               mid_adv;
   logic [7:0]         mem_data;

   // pipeline flow
   assign mid_adv      = mid_valid_ff && (!out_valid_ff || rsp_tready);
   assign mid_ready    = !mid_valid_ff || mid_adv;
   assign mid_valid_in = mid_load || (mid_valid_ff && !mid_adv);
   assign out_valid_in = mid_adv || (out_valid_ff && !rsp_tready);

   // read data of the memory this beat used
   always_comb begin
      case (mid_ff.src)
         vrp_pkg::SRC_SPRITE:    mem_data = sprite_rd;
         vrp_pkg::SRC_PATTERN:   mem_data = pattern_rd;
         vrp_pkg::SRC_NAMETABLE: mem_data = nametable_rd;
         default:                mem_data = {2'b00, palette_rd};
      endcase
   end

   // open-bus and read buffer update
   always_comb begin
      open_bus_in    = open_bus_ff;
      read_buffer_in = read_buffer_ff;
      case (mid_ff.ob_op)
         vrp_pkg::OB_LOAD:   open_bus_in = mid_ff.wr_byte;
         vrp_pkg::OB_STATUS: open_bus_in = {mid_ff.status, open_bus_ff[4:0]};
         vrp_pkg::OB_MEM:    open_bus_in = mem_data;
         vrp_pkg::OB_BUFFER: begin
            open_bus_in    = read_buffer_ff;
            read_buffer_in = mem_data;
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff   <= 1'b0;
         out_valid_ff   <= 1'b0;
         open_bus_ff    <= 8'd0;
         read_buffer_ff <= 8'd0;
      end else begin
         mid_valid_ff <= mid_valid_in;
         out_valid_ff <= out_valid_in;
         if (mid_adv) begin
            open_bus_ff    <= open_bus_in;
            read_buffer_ff <= read_buffer_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (mid_load) begin
         mid_ff <= mid_data;
      end
      if (mid_adv) begin
         out_ff.read_data <= open_bus_in;
         out_ff.nmi       <= mid_ff.nmi;
         out_ff.vram      <= mid_ff.vram;
         out_ff.fine      <= mid_ff.fine;
         out_ff.control   <= mid_ff.control;
         out_ff.mask      <= mid_ff.mask;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp        = out_ff;

`ifndef SYNTHESIS
   // a held result blocks stage two
   a_stall_holds_mid: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_tready |-> !mid_adv)
      else $error("stage two advanced into a stalled result");

   // the pending result always shows the current open-bus latch
   a_result_matches_bus: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_ff.read_data == open_bus_ff)
      else $error("result byte differs from open-bus latch");

   // buffered read refills the buffer from memory
   a_buffer_refill: assert property (@(posedge clock) disable iff (reset)
      mid_adv && (mid_ff.ob_op == vrp_pkg::OB_BUFFER)
      |=> read_buffer_ff == $past(mem_data))
      else $error("read buffer not refilled");
`endif

endmodule
